// File: rtl/hfr_pkg.sv
// ----------------------------------------------------------------------------
// HDLC frame receiver package
// Shared types, byte codes and defaults for the frame receiver.
// ----------------------------------------------------------------------------
package hfr_pkg;

    // Special byte codes on the link.
    localparam logic [7:0] ESC_BYTE  = 8'h7d;
    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] EXT_MASK  = 8'h80;
    localparam logic [6:0] TYPE_MASK = 7'h7f;
    localparam logic [7:0] FLIP_MASK = 8'h20;

    // Defaults.
    localparam int          DEF_BUFFER_BYTES = 1024;
    localparam logic [7:0]  TYPE_LIMIT_RESET = 8'd16;

    // Frame event codes.
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_DISCARD  = 2'd2;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TYPE,
        PH_RSV,
        PH_PORT,
        PH_LEN,
        PH_DATA,
        PH_SUM,
        PH_DONE
    } t_phase;

    // Class of a received word as sorted by the front end.
    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_ESCAPE,
        KIND_FLAG
    } t_kind;

    // Classified word handed from the front end to the back end.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] raw;
        logic [7:0] data;
    } t_item;

    // Queue write side between front and back.
    typedef struct packed {
        logic  push;
        t_item item;
    } t_push;

endpackage

// File: rtl/hfr_in_if.sv
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel that carries one raw received byte per word.
// ----------------------------------------------------------------------------
interface hfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/hfr_out_if.sv
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel that carries one parser result per word.
// ----------------------------------------------------------------------------
interface hfr_out_if;
    logic        valid;
    logic        ready;
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [1:0]  frame_event;
    logic [6:0]  frame_type;
    logic        extended_form;
    logic [7:0]  reserved_value;
    logic [7:0]  port_number;
    logic [14:0] payload_length;
    logic [7:0]  computed_sum;
    logic [15:0] received_sum;

    modport source (
        output valid, input ready,
        output byte_valid, output data_byte, output byte_index, output frame_event,
        output frame_type, output extended_form, output reserved_value,
        output port_number, output payload_length, output computed_sum,
        output received_sum
    );
    modport sink (
        input valid, output ready,
        input byte_valid, input data_byte, input byte_index, input frame_event,
        input frame_type, input extended_form, input reserved_value,
        input port_number, input payload_length, input computed_sum,
        input received_sum
    );
endinterface

// File: rtl/hfr_front.sv
// ----------------------------------------------------------------------------
// HDLC receiver front end
// Accepts raw bytes, tracks the escape state and classifies each word.
// ----------------------------------------------------------------------------
module hfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hfr_in_if.sink        i_in,
    input  logic          i_full,
    output hfr_pkg::t_push o_push
);
    import hfr_pkg::*;

    logic r_esc;
    logic n_esc;
    logic accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // Classify the word and undo the escape on ordinary bytes.
    always_comb begin
        n_esc              = r_esc;
        o_push.push        = accept;
        o_push.item.raw    = i_in.rx_byte;
        o_push.item.data   = i_in.rx_byte;
        o_push.item.kind   = KIND_NORMAL;
        if (i_in.rx_byte == ESC_BYTE) begin
            o_push.item.kind = KIND_ESCAPE;
            n_esc            = 1'b1;
        end else if (i_in.rx_byte == FLAG_BYTE) begin
            o_push.item.kind = KIND_FLAG;
            n_esc            = 1'b0;
        end else begin
            if (r_esc) begin
                o_push.item.data = i_in.rx_byte ^ FLIP_MASK;
            end
            n_esc = 1'b0;
        end
    end

    // Escape flag advances only on accepted words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else if (accept) begin
            r_esc <= n_esc;
        end
    end

endmodule

// File: rtl/hfr_fifo.sv
// ----------------------------------------------------------------------------
// HDLC receiver item queue
// Two-entry queue of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module hfr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hfr_pkg::t_push i_push,
    output logic           o_full,
    output logic           o_valid,
    output hfr_pkg::t_item o_item,
    input  logic           i_pop
);
    import hfr_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: rtl/hfr_back.sv
// ----------------------------------------------------------------------------
// HDLC receiver back end
// Runs the frame parser on classified words and registers each result.
// ----------------------------------------------------------------------------
module hfr_back #(
    parameter int BUFFER_BYTES = hfr_pkg::DEF_BUFFER_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_wdata,
    input  logic           i_valid,
    input  hfr_pkg::t_item i_item,
    output logic           o_pop,
    hfr_out_if.source      o_out
);
    import hfr_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES);

    // Parser state.
    t_phase        r_phase, n_phase;
    logic          r_ext, n_ext;
    logic [6:0]    r_type, n_type;
    logic [7:0]    r_rsv, n_rsv;
    logic [7:0]    r_port, n_port;
    logic [14:0]   r_len, n_len;
    logic [CW-1:0] r_count, n_count;
    logic          r_sidx, n_sidx;
    logic [7:0]    r_xor, n_xor;
    logic [15:0]   r_sum, n_sum;
    logic [7:0]    r_limit;

    // Output register.
    logic          r_out_valid;
    logic          r_bvalid, n_bvalid;
    logic [7:0]    r_dbyte, n_dbyte;
    logic [9:0]    r_dindex, n_dindex;
    logic [1:0]    r_event, n_event;

    logic [CW:0]   cnt1;
    logic [15:0]   idx_ext;
    logic [7:0]    b;

    assign o_pop   = i_valid && (!r_out_valid || o_out.ready);
    assign cnt1    = {1'b0, r_count} + (CW+1)'(1);
    assign idx_ext = 16'(r_count);
    assign b       = i_item.data;

    // Next-state logic for one word.
    always_comb begin
        n_phase  = r_phase;
        n_ext    = r_ext;
        n_type   = r_type;
        n_rsv    = r_rsv;
        n_port   = r_port;
        n_len    = r_len;
        n_count  = r_count;
        n_sidx   = r_sidx;
        n_xor    = r_xor;
        n_sum    = r_sum;
        n_bvalid = 1'b0;
        n_dbyte  = 8'd0;
        n_dindex = 10'd0;
        n_event  = EV_NONE;
        case (i_item.kind)
            KIND_ESCAPE: begin
            end
            KIND_FLAG: begin
                n_phase = PH_TYPE;
                n_ext   = 1'b0;
                n_len   = 15'd0;
                n_count = '0;
                n_sidx  = 1'b0;
                n_xor   = 8'd0;
                n_sum   = 16'd0;
            end
            KIND_NORMAL: begin
                if (r_phase != PH_SUM) begin
                    n_xor = r_xor ^ i_item.raw;
                end
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_TYPE: begin
                        if ({1'b0, b[6:0]} < r_limit) begin
                            n_type  = b[6:0] & TYPE_MASK;
                            n_ext   = (b & EXT_MASK) != 8'd0;
                            n_phase = ((b & EXT_MASK) != 8'd0) ? PH_RSV : PH_LEN;
                        end else begin
                            n_phase = PH_IDLE;
                            n_ext   = 1'b0;
                            n_len   = 15'd0;
                            n_count = '0;
                            n_sidx  = 1'b0;
                            n_xor   = 8'd0;
                            n_sum   = 16'd0;
                            n_event = EV_DISCARD;
                        end
                    end
                    PH_RSV: begin
                        n_rsv   = b;
                        n_phase = PH_PORT;
                    end
                    PH_PORT: begin
                        n_port  = b;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        if (r_len != 15'd0) begin
                            n_len   = r_len | {b, 7'd0};
                            n_phase = PH_DATA;
                        end else begin
                            n_len = {8'd0, b[6:0]};
                            if ((b & EXT_MASK) == 8'd0) begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_bvalid = 1'b1;
                        n_dbyte  = b;
                        n_dindex = idx_ext[9:0];
                        n_count  = cnt1[CW-1:0];
                        if (cnt1 >= (CW+1)'(BUFFER_BYTES - 1)) begin
                            // Buffer full wins over completion.
                            n_phase = PH_IDLE;
                            n_ext   = 1'b0;
                            n_len   = 15'd0;
                            n_count = '0;
                            n_sidx  = 1'b0;
                            n_xor   = 8'd0;
                            n_sum   = 16'd0;
                            n_event = EV_DISCARD;
                        end else if (16'(cnt1) >= {1'b0, r_len}) begin
                            if (r_ext) begin
                                n_sidx  = 1'b0;
                                n_phase = PH_SUM;
                            end else begin
                                n_phase = PH_DONE;
                                n_event = EV_COMPLETE;
                            end
                        end
                    end
                    PH_SUM: begin
                        if (r_sidx) begin
                            n_sum   = r_sum | {b, 8'd0};
                            n_phase = PH_DONE;
                            n_event = EV_COMPLETE;
                        end else begin
                            n_sum  = r_sum | {8'd0, b};
                            n_sidx = 1'b1;
                        end
                    end
                    PH_DONE: begin
                        n_phase = PH_IDLE;
                        n_ext   = 1'b0;
                        n_len   = 15'd0;
                        n_count = '0;
                        n_sidx  = 1'b0;
                        n_xor   = 8'd0;
                        n_sum   = 16'd0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Parser state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ext   <= 1'b0;
            r_type  <= 7'd0;
            r_rsv   <= 8'd0;
            r_port  <= 8'd0;
            r_len   <= 15'd0;
            r_count <= '0;
            r_sidx  <= 1'b0;
            r_xor   <= 8'd0;
            r_sum   <= 16'd0;
            r_limit <= TYPE_LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_phase <= n_phase;
                r_ext   <= n_ext;
                r_type  <= n_type;
                r_rsv   <= n_rsv;
                r_port  <= n_port;
                r_len   <= n_len;
                r_count <= n_count;
                r_sidx  <= n_sidx;
                r_xor   <= n_xor;
                r_sum   <= n_sum;
            end
        end
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Per-word result fields; the frame fields follow the parser state.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bvalid <= n_bvalid;
            r_dbyte  <= n_dbyte;
            r_dindex <= n_dindex;
            r_event  <= n_event;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.byte_valid     = r_bvalid;
    assign o_out.data_byte      = r_dbyte;
    assign o_out.byte_index     = r_dindex;
    assign o_out.frame_event    = r_event;
    assign o_out.frame_type     = r_type;
    assign o_out.extended_form  = r_ext;
    assign o_out.reserved_value = r_rsv;
    assign o_out.port_number    = r_port;
    assign o_out.payload_length = r_len;
    assign o_out.computed_sum   = r_xor;
    assign o_out.received_sum   = r_sum;

endmodule

// File: rtl/hdlc_frame_receiver.sv
// Path: an accepted byte is written into the queue storage, then its result goes to the output register.
// Throughput: one byte per cycle while the result side holds ready high, set by the
// parser update in the back end; a two-entry queue and the output register absorb stalls.
// Reset: synchronous active-low reset returns the parser to idle, empties the
// queue and the output register, and sets the type limit to 16.
// ----------------------------------------------------------------------------
// HDLC frame receiver
// Byte-stuffed frame deframer with a classifying front end and a parser
// back end joined by a short queue.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver #(
    parameter int BUFFER_BYTES = hfr_pkg::DEF_BUFFER_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    hfr_in_if.sink     i_in,
    hfr_out_if.source  o_out
);
    import hfr_pkg::*;

    t_push q_push;
    t_item q_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    // Front end: escape tracking and classification.
    hfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push)
    );

    // Queue between the two ends.
    hfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // Back end: frame parser and result register.
    hfr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule

// File: tb/tb_hdlc_frame_receiver.sv
// ----------------------------------------------------------------------------
// HDLC frame receiver testbench
// Drives escaped byte streams into the deframer: hand-picked frames first,
// then random frames mixed with noise and broken frames. Every byte yields one
// result word. An internal model of the parser predicts each word, and the
// scoreboard compares it field by field. Both channels idle at random rates,
// and the type limit is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_hdlc_frame_receiver;
    import hfr_pkg::*;

    localparam int          BUF_BYTES   = DEF_BUFFER_BYTES;
    localparam int unsigned CYCLE_LIMIT = 300000;

    // One result word as seen on the output channel.
    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  data_byte;
        logic [9:0]  byte_index;
        logic [1:0]  frame_event;
        logic [6:0]  frame_type;
        logic        extended_form;
        logic [7:0]  reserved_value;
        logic [7:0]  port_number;
        logic [14:0] payload_length;
        logic [7:0]  computed_sum;
        logic [15:0] received_sum;
    } t_frame_result;

    // Frame parser model and the queue of result words it predicts.
    class frame_scoreboard;
        t_phase          ph;
        logic            esc_armed;
        logic            ext_form;
        logic [6:0]      hdr_type;
        logic [7:0]      rsv_q;
        logic [7:0]      port_q;
        logic [14:0]     decl_len;
        int unsigned     stored;
        logic            sum_hi_next;
        logic [7:0]      xor_acc;
        logic [15:0]     rx_sum;
        logic [7:0]      type_limit;
        t_frame_result   pending[$];
        int unsigned     errors;

        function new();
            clear_frame();
            hdr_type   = '0;
            rsv_q      = '0;
            port_q     = '0;
            type_limit = TYPE_LIMIT_RESET;
            errors     = 0;
        endfunction

        // A flag or a discard clears the frame but keeps the header bytes.
        function void clear_frame();
            ph          = PH_IDLE;
            esc_armed   = 1'b0;
            ext_form    = 1'b0;
            decl_len    = '0;
            stored      = 0;
            sum_hi_next = 1'b0;
            xor_acc     = '0;
            rx_sum      = '0;
        endfunction

        function void set_limit(logic [7:0] value);
            type_limit = value;
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction

        // Update the model with one accepted word and queue its result.
        function void note_byte(logic [7:0] raw);
            logic [7:0]    b;
            t_frame_result r;
            r = '0;
            b = raw;
            if (raw == ESC_BYTE) begin
                esc_armed = 1'b1;
            end else if (raw == FLAG_BYTE) begin
                clear_frame();
                ph = PH_TYPE;
            end else begin
                // The checksum covers the escaped value, except in the sum bytes.
                if (ph != PH_SUM) xor_acc = xor_acc ^ raw;
                if (esc_armed) begin
                    esc_armed = 1'b0;
                    b = b ^ FLIP_MASK;
                end
                case (ph)
                    PH_TYPE: begin
                        if ({1'b0, b[6:0]} < type_limit) begin
                            hdr_type = b[6:0];
                            ext_form = b[7];
                            ph = b[7] ? PH_RSV : PH_LEN;
                        end else begin
                            clear_frame();
                            r.frame_event = EV_DISCARD;
                        end
                    end
                    PH_RSV: begin
                        rsv_q = b;
                        ph = PH_PORT;
                    end
                    PH_PORT: begin
                        port_q = b;
                        ph = PH_LEN;
                    end
                    PH_LEN: begin
                        // A first byte of exactly 0x80 leaves the length at zero,
                        // so the next byte is read as a first byte again.
                        if (decl_len != 0) begin
                            decl_len = decl_len | {b, 7'd0};
                            ph = PH_DATA;
                        end else begin
                            decl_len = {8'd0, b[6:0]};
                            if (!b[7]) ph = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        r.byte_valid = 1'b1;
                        r.data_byte  = b;
                        r.byte_index = 10'(stored);
                        stored++;
                        // A full buffer wins over completion.
                        if (stored >= BUF_BYTES - 1) begin
                            clear_frame();
                            r.frame_event = EV_DISCARD;
                        end else if (stored >= decl_len) begin
                            if (ext_form) begin
                                sum_hi_next = 1'b0;
                                ph = PH_SUM;
                            end else begin
                                ph = PH_DONE;
                                r.frame_event = EV_COMPLETE;
                            end
                        end
                    end
                    PH_SUM: begin
                        if (sum_hi_next) begin
                            rx_sum = rx_sum | {b, 8'd0};
                            ph = PH_DONE;
                            r.frame_event = EV_COMPLETE;
                        end else begin
                            rx_sum = rx_sum | {8'd0, b};
                            sum_hi_next = 1'b1;
                        end
                    end
                    PH_DONE: clear_frame();
                    default: ;
                endcase
            end
            r.frame_type     = hdr_type;
            r.extended_form  = ext_form;
            r.reserved_value = rsv_q;
            r.port_number    = port_q;
            r.payload_length = decl_len;
            r.computed_sum   = xor_acc;
            r.received_sum   = rx_sum;
            pending.push_back(r);
        endfunction

        function void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, exp_v, got_v);
            end
        endfunction

        // Compare one accepted result word with the oldest prediction.
        function void check_result(t_frame_result got);
            t_frame_result exp_r;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %p",
                         $time, got);
                return;
            end
            exp_r = pending.pop_front();
            check_field("byte_valid", 16'(exp_r.byte_valid), 16'(got.byte_valid));
            check_field("data_byte", 16'(exp_r.data_byte), 16'(got.data_byte));
            check_field("byte_index", 16'(exp_r.byte_index), 16'(got.byte_index));
            check_field("frame_event", 16'(exp_r.frame_event), 16'(got.frame_event));
            check_field("frame_type", 16'(exp_r.frame_type), 16'(got.frame_type));
            check_field("extended_form", 16'(exp_r.extended_form),
                        16'(got.extended_form));
            check_field("reserved_value", 16'(exp_r.reserved_value),
                        16'(got.reserved_value));
            check_field("port_number", 16'(exp_r.port_number), 16'(got.port_number));
            check_field("payload_length", 16'(exp_r.payload_length),
                        16'(got.payload_length));
            check_field("computed_sum", 16'(exp_r.computed_sum), 16'(got.computed_sum));
            check_field("received_sum", exp_r.received_sum, got.received_sum);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    logic [7:0]  cur_limit = TYPE_LIMIT_RESET;
    logic [7:0]  link_bytes[$];

    frame_scoreboard sb = new();

    hfr_in_if  rx_if();
    hfr_out_if res_if();

    hdlc_frame_receiver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (rx_if),
        .o_out       (res_if)
    );

    // Clock generation.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check each accepted word and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result('{res_if.byte_valid, res_if.data_byte, res_if.byte_index,
                              res_if.frame_event, res_if.frame_type, res_if.extended_form,
                              res_if.reserved_value, res_if.port_number,
                              res_if.payload_length, res_if.computed_sum,
                              res_if.received_sum});
        end
        res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Queue one logical byte, escaping it where the link requires or at random.
    function automatic void push_escaped(logic [7:0] v);
        logic [7:0] flipped;
        flipped = v ^ FLIP_MASK;
        if (v == ESC_BYTE || v == FLAG_BYTE ||
            (flipped != ESC_BYTE && flipped != FLAG_BYTE && $urandom_range(0, 19) == 0)) begin
            link_bytes.push_back(ESC_BYTE);
            link_bytes.push_back(flipped);
        end else begin
            link_bytes.push_back(v);
        end
    endfunction

    // Queue one frame with random content. A nonzero forced_len fixes the length.
    function automatic void add_frame(int unsigned forced_len);
        logic [6:0]  t;
        logic        ext;
        int unsigned len;
        int unsigned n;
        link_bytes.push_back(FLAG_BYTE);
        ext = 1'($urandom_range(0, 1));
        if (forced_len == 0 && cur_limit < 8'd128 && $urandom_range(0, 9) == 0) begin
            // Rejected type: the frame is dropped at once.
            t = 7'($urandom_range(cur_limit, 127));
            push_escaped({ext, t});
            return;
        end
        t = 7'($urandom_range(0, cur_limit - 1));
        push_escaped({ext, t});
        if (ext) begin
            push_escaped(8'($urandom));
            push_escaped(8'($urandom));
        end
        if (forced_len != 0)
            len = forced_len;
        else if ($urandom_range(0, 19) == 0)
            len = $urandom_range(128, 300);
        else
            len = $urandom_range(0, 12);
        if ($urandom_range(0, 7) == 0) push_escaped(EXT_MASK);
        if (len >= 128 || (len % 128 != 0 && $urandom_range(0, 2) == 0)) begin
            if (len % 128 == 0) len++;
            push_escaped(EXT_MASK | 8'(len % 128));
            push_escaped(8'(len / 128));
        end else begin
            push_escaped(8'(len));
        end
        // A zero length still takes one payload byte; a full buffer ends early.
        n = (len == 0) ? 1 : len;
        if (n > BUF_BYTES - 1) n = BUF_BYTES - 1;
        if (forced_len == 0 && $urandom_range(0, 14) == 0) begin
            // Broken frame: cut short, the next flag abandons it.
            n = $urandom_range(0, n - 1);
            repeat (n) push_escaped(8'($urandom));
            return;
        end
        repeat (n) push_escaped(8'($urandom));
        if (ext && len < BUF_BYTES - 1) begin
            push_escaped(8'($urandom));
            push_escaped(8'($urandom));
        end
        if ($urandom_range(0, 2) == 0) push_escaped(8'($urandom));
    endfunction

    // Send every queued byte, idling before each one at the sender rate.
    task automatic send_link_bytes();
        logic [7:0] b;
        while (link_bytes.size() > 0) begin
            b = link_bytes.pop_front();
            while ($urandom_range(0, 99) < snd_idle_pct) begin
                rx_if.valid <= 1'b0;
                @(posedge i_clk);
            end
            rx_if.valid   <= 1'b1;
            rx_if.rx_byte <= b;
            do @(posedge i_clk); while (!rx_if.ready);
            sb.note_byte(b);
            bytes_sent++;
        end
    endtask

    // Hold the sender until every predicted word has been checked.
    task automatic wait_for_results();
        rx_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Change the type limit while the block is idle.
    task automatic write_limit(logic [7:0] value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_limit(value);
        cur_limit = value;
    endtask

    // Random frames and noise until about n_items words have gone in.
    task automatic run_random(int unsigned n_items);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4)) link_bytes.push_back(8'($urandom));
            else
                add_frame(0);
            send_link_bytes();
            if ($urandom_range(0, 24) == 0) wait_for_results();
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset type limit. Extended frame with the
        // 0x80 length quirk, two-byte length and escaped payload and checksum,
        // then a byte after completion.
        link_bytes = '{8'h7e, 8'h8f, 8'hff, 8'h00, 8'h80, 8'h82, 8'h00, 8'h7d, 8'h5e,
                       8'h00, 8'hff, 8'h7d, 8'h5d, 8'h55};
        // Type at the limit is rejected.
        link_bytes.push_back(8'h7e);
        link_bytes.push_back(8'h10);
        // Zero length still takes one byte.
        link_bytes.push_back(8'h7e);
        link_bytes.push_back(8'h00);
        link_bytes.push_back(8'h00);
        link_bytes.push_back(8'haa);
        // Escape then flag, a doubled escape, and a restart in mid-frame.
        link_bytes.push_back(8'h7e);
        link_bytes.push_back(8'h7d);
        link_bytes.push_back(8'h7e);
        link_bytes.push_back(8'h01);
        link_bytes.push_back(8'h7d);
        link_bytes.push_back(8'h7d);
        link_bytes.push_back(8'h23);
        link_bytes.push_back(8'h11);
        link_bytes.push_back(8'h7e);
        send_link_bytes();

        // Phase one: lowest limit, sender idles a little, receiver a lot.
        snd_idle_pct = 21;
        rcv_idle_pct = 58;
        write_limit(8'd1);
        run_random(70);

        // Phase two: highest limit, idling the other way round.
        snd_idle_pct = 58;
        rcv_idle_pct = 21;
        write_limit(8'd128);
        run_random(70);

        // Phase three: no idling, a middle limit, and one frame that fills
        // the buffer.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_limit(8'($urandom_range(2, 127)));
        add_frame(1100);
        send_link_bytes();
        run_random(70);

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
